// ----- hw/rtl/btr_pkg.sv -----
// Shared types and constants for the 2x2 binary threshold reduction block.
// Used by the register file, the reduction core, the result buffer and the top level.
// No dependencies.
`timescale 1ns / 1ps

package btr_pkg;

   // Default for the widest supported input row, in pixels.
   localparam int BTR_MAX_WIDTH = 4096;

   // Rows per frame are capped at a fixed bound.
   localparam int MAX_HEIGHT = 4096;
   localparam int ROW_W      = 12;
   localparam int DIM_W      = 13;
   localparam int THR_W      = 3;

   // Register file layout: one 32-bit register every four bytes.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 3'd1;
   localparam logic [DIM_W-1:0] WIDTH_RESET     = 13'd4096;
   localparam logic [DIM_W-1:0] HEIGHT_RESET    = 13'd4096;

   typedef struct packed {
      logic [THR_W-1:0] threshold;
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
   } cfg_type;

   typedef struct packed {
      logic pixel_out;
      logic row_end;
      logic frame_end;
   } res_type;

endpackage

// ----- hw/rtl/btr_csr.sv -----
// APB-style register file holding threshold, image width and image height.
// Depends on btr_pkg for the register layout and the configuration struct.
`timescale 1ns / 1ps

module btr_csr
   import btr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   wr_en;
   logic [CSR_IDX_W-1:0]   reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_THRESHOLD:    cfg_in.threshold    = pwdata[THR_W-1:0];
            REG_IMAGE_WIDTH:  cfg_in.image_width  = pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: cfg_in.image_height = pwdata[DIM_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold    <= THRESHOLD_RESET;
         cfg_ff.image_width  <= WIDTH_RESET;
         cfg_ff.image_height <= HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_THRESHOLD:    prdata = CSR_DATA_W'(cfg_ff.threshold);
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.image_height);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/btr_core.sv -----
// Reduction core: raster counters, the even-row pair-sum store and the block threshold.
// Depends on btr_pkg for the configuration and result structs.
`timescale 1ns / 1ps

module btr_core
   import btr_pkg::*;
#(
   parameter int MAX_WIDTH = BTR_MAX_WIDTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    pix_accept,
   input  logic    pixel_in,
   output logic    res_valid,
   output res_type res
);

   localparam int DEPTH = MAX_WIDTH / 2;
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = (WW > DIM_W) ? WW : DIM_W;

   // Limits derived from the registers, taken through a register. Configuration must change
   // only while idle (the block itself does not enforce this), so the registered copy is harmless.
   logic [XW-1:0]    w_raw;
   logic [XW-1:0]    w_eff;
   logic [DIM_W-1:0] h_eff;
   logic [WW-1:0]    w_pairs;
   logic [DIM_W-1:0] h_pairs;

   logic [CW-1:0]    col_last_ff, col_last_in;
   logic [CW-1:0]    col_pair_last_ff, col_pair_last_in;
   logic [ROW_W-1:0] row_last_ff, row_last_in;
   logic [ROW_W-1:0] row_pair_last_ff, row_pair_last_in;

   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             held_ff, held_in;
   logic [1:0]       rd_ff;
   logic [1:0]       pair_sum_mem_ff [DEPTH];

   logic             in_blk;
   logic             odd_col;
   logic             odd_row;
   logic [AW-1:0]    addr;
   logic [1:0]       pair;
   logic [2:0]       count;

   always_comb begin
      w_raw = XW'(cfg.image_width);
      if (w_raw < XW'(2)) begin
         w_eff = XW'(2);
      end else if (w_raw > XW'(MAX_WIDTH)) begin
         w_eff = XW'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      if (cfg.image_height < DIM_W'(2)) begin
         h_eff = DIM_W'(2);
      end else if (cfg.image_height > DIM_W'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = cfg.image_height;
      end
      w_pairs          = WW'(w_eff) & ~WW'(1);
      h_pairs          = h_eff & ~DIM_W'(1);
      col_last_in      = CW'(w_eff - XW'(1));
      col_pair_last_in = CW'(w_pairs - WW'(1));
      row_last_in      = ROW_W'(h_eff - DIM_W'(1));
      row_pair_last_in = ROW_W'(h_pairs - DIM_W'(1));
   end

   always_ff @(posedge clock) begin
      col_last_ff      <= col_last_in;
      col_pair_last_ff <= col_pair_last_in;
      row_last_ff      <= row_last_in;
      row_pair_last_ff <= row_pair_last_in;
   end

   assign in_blk  = (col_ff <= col_pair_last_ff) && (row_ff <= row_pair_last_ff);
   assign odd_col = col_ff[0];
   assign odd_row = row_ff[0];
   assign addr    = col_ff[AW:1];
   assign pair    = {1'b0, held_ff} + {1'b0, pixel_in};
   assign count   = {1'b0, rd_ff} + {2'b00, held_ff} + {2'b00, pixel_in};

   // A pixel in the dropped last column or row still advances the counters.
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      held_in = held_ff;
      if (pix_accept) begin
         if (in_blk && !odd_col) begin
            held_in = pixel_in;
         end
         if (col_ff >= col_last_ff) begin
            col_in = '0;
            row_in = (row_ff >= row_last_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         held_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         held_ff <= held_in;
      end
   end

   // The stored pair sum is fetched on the even pixel of an odd row, so it is
   // ready by the time the odd pixel of the same pair arrives.
   always_ff @(posedge clock) begin
      if (pix_accept && in_blk) begin
         if (odd_col && !odd_row) begin
            pair_sum_mem_ff[addr] <= pair;
         end
         if (!odd_col && odd_row) begin
            rd_ff <= pair_sum_mem_ff[addr];
         end
      end
   end

   assign res_valid     = pix_accept && in_blk && odd_col && odd_row;
   assign res.pixel_out = (count >= cfg.threshold);
   assign res.row_end   = (col_ff == col_pair_last_ff);
   assign res.frame_end = (col_ff == col_pair_last_ff) && (row_ff == row_pair_last_ff);

endmodule

// ----- hw/rtl/btr_obuf.sv -----
// Two-entry result buffer that registers the reduced pixels for the output channel.
// Depends on btr_pkg for the result struct.
`timescale 1ns / 1ps

module btr_obuf
   import btr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  res_type push_res,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output res_type rsp_res
);

   logic [1:0] cnt_ff, cnt_in;
   res_type    head_ff, head_in;
   res_type    tail_ff, tail_in;
   logic       pop;

   assign pop = rsp_valid & ~rsp_stall;

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      case (cnt_ff)
         2'd0: begin
            if (push) begin
               head_in = push_res;
               cnt_in  = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = push_res;
            end else if (push) begin
               tail_in = push_res;
               cnt_in  = 2'd2;
            end else if (pop) begin
               cnt_in = 2'd0;
            end
         end
         2'd2: begin
            // The input side is stalled while both entries are held.
            if (pop) begin
               head_in = tail_ff;
               cnt_in  = 2'd1;
            end
         end
         default: cnt_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign full      = (cnt_ff == 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_res   = head_ff;

endmodule

// ----- hw/rtl/binary_threshold_reduction_2x2.sv -----
// Channel    Direction  Signals                                          Beat
// req        in         req_valid, req_stall, req_pixel_in               one input pixel
// rsp        out        rsp_valid, rsp_stall, rsp_pixel_out/row_end/     one reduced pixel
//                       rsp_frame_end
// csr        in/out     psel, penable, pwrite, paddr, pwdata, prdata,    register access
//                       pready
//
// One pixel is taken every clock unless the input is stalled; the beat that
// completes a 2x2 block pushes its reduced pixel into the registered output
// buffer. The row store read happens on the even pixel of a pair, so the
// store's single read port sets no extra delay. The input stalls only while two
// finished results wait in the output buffer. Reset is synchronous and clears the
// counters; the row store is not cleared.
// Top level of the 2x2 binary threshold reduction block.
// Depends on btr_pkg, btr_csr, btr_core and btr_obuf.
`timescale 1ns / 1ps

module binary_threshold_reduction_2x2
   import btr_pkg::*;
#(
   parameter int MAX_WIDTH = BTR_MAX_WIDTH
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_pixel_out,
   output logic                  rsp_row_end,
   output logic                  rsp_frame_end,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;
   res_type core_res;
   res_type out_res;
   logic    core_res_valid;
   logic    pix_accept;
   logic    buf_full;

   assign req_stall  = buf_full;
   assign pix_accept = req_valid & ~buf_full;

   btr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   btr_core #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pix_accept (pix_accept),
      .pixel_in   (req_pixel_in),
      .res_valid  (core_res_valid),
      .res        (core_res)
   );

   btr_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (core_res_valid),
      .push_res  (core_res),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (out_res)
   );

   assign rsp_pixel_out = out_res.pixel_out;
   assign rsp_row_end   = out_res.row_end;
   assign rsp_frame_end = out_res.frame_end;

endmodule

// ----- hw/rtl/btr_checker.sv -----
// Port-level checks for the 2x2 binary threshold reduction block, and the bind
// that attaches them to the top level. No package dependency.
`timescale 1ns / 1ps

module btr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_pixel_out,
   input logic rsp_row_end,
   input logic rsp_frame_end,
   input logic pready
);

   // A held result beat keeps its payload until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
         && $stable(rsp_row_end) && $stable(rsp_frame_end))
      else $error("stalled result beat changed");

   // The last pixel of a frame also closes its reduced row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   // The input is only held off while results are waiting.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no pending result");

   // Reset empties the output buffer.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      req_valid |-> pready)
      else $error("register port not ready");

endmodule

bind binary_threshold_reduction_2x2 btr_checker u_btr_checker (.*);
